>>> hw/rtl/clns_pkg.sv
// Shared types, codes and the microcode ROM for the character-LCD nibble sequencer.
package clns_pkg;

    localparam int OP_W      = 3;
    localparam int CHAR_W    = 8;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 6;
    localparam int NIB_W     = 4;
    localparam int WB_W      = 11;
    localparam int WA_W      = 13;
    localparam int ROWLEN_W  = 6;
    localparam int STEP_W    = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RESET = 6'd20;

    localparam logic [OP_W-1:0] OP_INIT       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUTCH      = 3'd1;
    localparam logic [OP_W-1:0] OP_GOTO       = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
    localparam logic [OP_W-1:0] OP_HOME       = 3'd4;
    localparam logic [OP_W-1:0] OP_CUR_OFF    = 3'd5;
    localparam logic [OP_W-1:0] OP_CUR_BLINK  = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE       = 3'd7;

    // byte source
    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_CHAR  = 2'd1;
    localparam logic [1:0] SRC_POS   = 2'd2;

    localparam logic HALF_HI = 1'b1;
    localparam logic HALF_LO = 1'b0;

    localparam logic WB_NONE   = 1'b0;
    localparam logic WB_SETTLE = 1'b1;

    localparam logic [1:0] WA_STROBE = 2'd0;
    localparam logic [1:0] WA_FIRST  = 2'd1;
    localparam logic [1:0] WA_SECOND = 2'd2;
    localparam logic [1:0] WA_LONG   = 2'd3;

    localparam logic [WB_W-1:0] WB_SETTLE_US = 11'd1505;
    localparam logic [WA_W-1:0] WA_STROBE_US = 13'd40;
    localparam logic [WA_W-1:0] WA_FIRST_US  = 13'd4145;
    localparam logic [WA_W-1:0] WA_SECOND_US = 13'd145;
    localparam logic [WA_W-1:0] WA_LONG_US   = 13'd1640;

    localparam logic [CHAR_W-1:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [CHAR_W-1:0] CMD_DISP_OFFC  = 8'h0C;
    localparam logic [CHAR_W-1:0] CMD_DISP_BLINK = 8'h0F;
    localparam logic [CHAR_W-1:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [CHAR_W-1:0] CMD_CLEAR      = 8'h01;
    localparam logic [CHAR_W-1:0] CMD_HOME       = 8'h02;
    localparam logic [CHAR_W-1:0] CMD_WAKE       = 8'h30;
    localparam logic [CHAR_W-1:0] CMD_4BIT       = 8'h20;
    localparam logic [CHAR_W-1:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [CHAR_W-1:0] ODD_ROW_OFFSET = 8'h40;

    // program entry points
    localparam logic [STEP_W-1:0] ENTRY_INIT   = 5'd0;
    localparam logic [STEP_W-1:0] ENTRY_PUTCH  = 5'd10;
    localparam logic [STEP_W-1:0] ENTRY_GOTO   = 5'd12;
    localparam logic [STEP_W-1:0] ENTRY_CLEAR  = 5'd14;
    localparam logic [STEP_W-1:0] ENTRY_HOME   = 5'd16;
    localparam logic [STEP_W-1:0] ENTRY_CUROFF = 5'd18;
    localparam logic [STEP_W-1:0] ENTRY_BLINK  = 5'd20;
    localparam logic [STEP_W-1:0] STEP_END     = 5'd21;

    localparam logic [PADDR_W-1:0] ADDR_ROW_LENGTH = 3'd0;

    typedef struct packed {
        logic              rs;
        logic [1:0]        src;
        logic              half;
        logic [CHAR_W-1:0] data;
        logic              wb_sel;
        logic [1:0]        wa_sel;
        logic              last;
    } uc_word_t;

    typedef struct packed {
        logic     issue;
        uc_word_t word;
    } seq_ctl_t;

    function automatic uc_word_t uc_make(logic rs, logic [1:0] src, logic half,
                                         logic [CHAR_W-1:0] data, logic wb_sel,
                                         logic [1:0] wa_sel, logic last);
        uc_word_t w;
        w.rs     = rs;
        w.src    = src;
        w.half   = half;
        w.data   = data;
        w.wb_sel = wb_sel;
        w.wa_sel = wa_sel;
        w.last   = last;
        return w;
    endfunction

    function automatic uc_word_t uc_rom(logic [STEP_W-1:0] addr);
        uc_word_t w;
        w = uc_make(1'b0, SRC_CONST, HALF_HI, '0, WB_NONE, WA_STROBE, 1'b1);
        unique case (addr)
            5'd0:  w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_WAKE, WB_SETTLE, WA_FIRST, 1'b0);
            5'd1:  w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_WAKE, WB_NONE, WA_SECOND, 1'b0);
            5'd2:  w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_WAKE, WB_NONE, WA_STROBE, 1'b0);
            5'd3:  w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_4BIT, WB_NONE, WA_STROBE, 1'b0);
            5'd4:  w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_FUNC_SET, WB_NONE, WA_STROBE, 1'b0);
            5'd5:  w = uc_make(1'b0, SRC_CONST, HALF_LO, CMD_FUNC_SET, WB_NONE, WA_STROBE, 1'b0);
            5'd6:  w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_DISP_OFFC, WB_NONE, WA_STROBE, 1'b0);
            5'd7:  w = uc_make(1'b0, SRC_CONST, HALF_LO, CMD_DISP_OFFC, WB_NONE, WA_STROBE, 1'b0);
            5'd8:  w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_ENTRY_MODE, WB_NONE, WA_STROBE, 1'b0);
            5'd9:  w = uc_make(1'b0, SRC_CONST, HALF_LO, CMD_ENTRY_MODE, WB_NONE, WA_STROBE, 1'b1);
            5'd10: w = uc_make(1'b1, SRC_CHAR, HALF_HI, '0, WB_NONE, WA_STROBE, 1'b0);
            5'd11: w = uc_make(1'b1, SRC_CHAR, HALF_LO, '0, WB_NONE, WA_STROBE, 1'b1);
            5'd12: w = uc_make(1'b0, SRC_POS, HALF_HI, '0, WB_NONE, WA_STROBE, 1'b0);
            5'd13: w = uc_make(1'b0, SRC_POS, HALF_LO, '0, WB_NONE, WA_STROBE, 1'b1);
            5'd14: w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_CLEAR, WB_NONE, WA_STROBE, 1'b0);
            5'd15: w = uc_make(1'b0, SRC_CONST, HALF_LO, CMD_CLEAR, WB_NONE, WA_LONG, 1'b1);
            5'd16: w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_HOME, WB_NONE, WA_STROBE, 1'b0);
            5'd17: w = uc_make(1'b0, SRC_CONST, HALF_LO, CMD_HOME, WB_NONE, WA_LONG, 1'b1);
            5'd18: w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_DISP_OFFC, WB_NONE, WA_STROBE, 1'b0);
            5'd19: w = uc_make(1'b0, SRC_CONST, HALF_LO, CMD_DISP_OFFC, WB_NONE, WA_STROBE, 1'b1);
            5'd20: w = uc_make(1'b0, SRC_CONST, HALF_HI, CMD_DISP_BLINK, WB_NONE, WA_STROBE,
                               1'b0);
            5'd21: w = uc_make(1'b0, SRC_CONST, HALF_LO, CMD_DISP_BLINK, WB_NONE, WA_STROBE,
                               1'b1);
            default: w = uc_make(1'b0, SRC_CONST, HALF_HI, '0, WB_NONE, WA_STROBE, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] uc_entry(logic [OP_W-1:0] op);
        logic [STEP_W-1:0] a;
        a = ENTRY_INIT;
        unique case (op)
            OP_INIT:      a = ENTRY_INIT;
            OP_PUTCH:     a = ENTRY_PUTCH;
            OP_GOTO:      a = ENTRY_GOTO;
            OP_CLEAR:     a = ENTRY_CLEAR;
            OP_HOME:      a = ENTRY_HOME;
            OP_CUR_OFF:   a = ENTRY_CUROFF;
            OP_CUR_BLINK: a = ENTRY_BLINK;
            default:      a = ENTRY_INIT;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/clns_sequencer.sv
// Microcode sequencer: step counter, dispatch on operation, ROM fetch.
module clns_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [clns_pkg::OP_W-1:0]   operation,
    output logic                        in_ready,
    input  logic                        out_free,
    output clns_pkg::seq_ctl_t          ctl
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [clns_pkg::STEP_W-1:0]    step_reg;
    logic [clns_pkg::STEP_W-1:0]    step_next;
    logic                           in_fire;
    logic                           start;

    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign start    = in_fire && (operation != clns_pkg::OP_NONE);

    always_comb
    begin
        ctl.word  = clns_pkg::uc_rom(step_reg);
        ctl.issue = busy_reg && out_free;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = clns_pkg::uc_entry(operation);
        end
        else if (ctl.issue)
        begin
            if (ctl.word.last)
                busy_next = 1'b0;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("command start did not enter program");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= clns_pkg::STEP_END)
        else $error("step counter ran past program end");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.issue && ctl.word.last |=> !busy_reg)
        else $error("program did not stop after last word");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (operation == clns_pkg::OP_NONE) |=> !busy_reg)
        else $error("unused operation started a program");

endmodule

>>> hw/rtl/clns_datapath.sv
// Datapath: operand capture, DDRAM address, nibble select and output register.
module clns_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_fire,
    input  logic [clns_pkg::CHAR_W-1:0]     char_code,
    input  logic [clns_pkg::ROW_W-1:0]      row,
    input  logic [clns_pkg::COL_W-1:0]      col,
    input  logic [clns_pkg::ROWLEN_W-1:0]   row_length,
    input  clns_pkg::seq_ctl_t              ctl,
    output logic                            out_free,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            reg_select,
    output logic [clns_pkg::NIB_W-1:0]      nibble,
    output logic [clns_pkg::WB_W-1:0]       wait_before_us,
    output logic [clns_pkg::WA_W-1:0]       wait_after_us,
    output logic                            last
);

    logic [clns_pkg::CHAR_W-1:0]    char_reg;
    logic [clns_pkg::CHAR_W-1:0]    pos_reg;
    logic [clns_pkg::CHAR_W-1:0]    pos_next;
    logic [clns_pkg::ROW_W-1:0]     r;
    logic [clns_pkg::COL_W-1:0]     c;
    logic [clns_pkg::CHAR_W-1:0]    base;
    logic [clns_pkg::CHAR_W-1:0]    addr_sum;
    logic [clns_pkg::CHAR_W-1:0]    byte_sel;
    logic                           out_valid_reg;
    logic                           rs_reg;
    logic [clns_pkg::NIB_W-1:0]     nib_reg;
    logic [clns_pkg::WB_W-1:0]      wb_reg;
    logic [clns_pkg::WA_W-1:0]      wa_reg;
    logic                           last_reg;
    logic [clns_pkg::NIB_W-1:0]     nib_next;
    logic [clns_pkg::WB_W-1:0]      wb_next;
    logic [clns_pkg::WA_W-1:0]      wa_next;

    always_comb
    begin
        r        = row - 1'b1;
        c        = col - 1'b1;
        base     = 8'(r[2:1] * row_length);
        if (r[0])
            base = base + clns_pkg::ODD_ROW_OFFSET;
        addr_sum = base + {2'b00, c};
        pos_next = clns_pkg::CMD_SET_DDRAM | {1'b0, addr_sum[6:0]};
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            char_reg <= char_code;
            pos_reg  <= pos_next;
        end
    end

    always_comb
    begin
        case (ctl.word.src)
            clns_pkg::SRC_CHAR: byte_sel = char_reg;
            clns_pkg::SRC_POS:  byte_sel = pos_reg;
            default:            byte_sel = ctl.word.data;
        endcase
        nib_next = (ctl.word.half == clns_pkg::HALF_HI) ? byte_sel[7:4] : byte_sel[3:0];
        wb_next  = (ctl.word.wb_sel == clns_pkg::WB_SETTLE) ? clns_pkg::WB_SETTLE_US : '0;
        case (ctl.word.wa_sel)
            clns_pkg::WA_FIRST:  wa_next = clns_pkg::WA_FIRST_US;
            clns_pkg::WA_SECOND: wa_next = clns_pkg::WA_SECOND_US;
            clns_pkg::WA_LONG:   wa_next = clns_pkg::WA_LONG_US;
            default:             wa_next = clns_pkg::WA_STROBE_US;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.issue)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            rs_reg   <= ctl.word.rs;
            nib_reg  <= nib_next;
            wb_reg   <= wb_next;
            wa_reg   <= wa_next;
            last_reg <= ctl.word.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reg_select     = rs_reg;
    assign nibble         = nib_reg;
    assign wait_before_us = wb_reg;
    assign wait_after_us  = wa_reg;
    assign last           = last_reg;

    a_settle_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (wb_reg != '0) |-> !rs_reg && (nib_reg == 4'h3) && !last_reg)
        else $error("power-up settle on wrong transfer");

endmodule

>>> hw/rtl/char_lcd_nibble_sequencer.sv
// Top level: character-LCD 4-bit command to nibble transfer sequencer with APB config.
// The first transfer is issued once the step counter is loaded and the output register is free.
// Throughput: one transfer per cycle without output stalls; a command of n transfers
// (init 10, the others 2) holds off the input while it runs, the next request is taken
// the cycle after the last transfer is issued; an unused operation starts no program.
// Reset (rst_n, async low) idles the sequencer, empties the output and sets row_length to 20.
module char_lcd_nibble_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clns_pkg::PADDR_W-1:0]    paddr,
    input  logic [clns_pkg::PDATA_W-1:0]    pwdata,
    output logic [clns_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [clns_pkg::OP_W-1:0]       operation,
    input  logic [clns_pkg::CHAR_W-1:0]     char_code,
    input  logic [clns_pkg::ROW_W-1:0]      row,
    input  logic [clns_pkg::COL_W-1:0]      col,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            reg_select,
    output logic [clns_pkg::NIB_W-1:0]      nibble,
    output logic [clns_pkg::WB_W-1:0]       wait_before_us,
    output logic [clns_pkg::WA_W-1:0]       wait_after_us,
    output logic                            last
);

    logic [clns_pkg::ROWLEN_W-1:0]  row_length_reg;
    logic                           cfg_wr;
    logic                           in_fire;
    logic                           out_free;
    clns_pkg::seq_ctl_t             ctl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == clns_pkg::ADDR_ROW_LENGTH[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_length_reg <= clns_pkg::ROW_LENGTH_RESET;
        else if (cfg_wr)
            row_length_reg <= pwdata[clns_pkg::ROWLEN_W-1:0];
    end

    assign prdata = (paddr[2] == clns_pkg::ADDR_ROW_LENGTH[2]) ?
                    {{(clns_pkg::PDATA_W-clns_pkg::ROWLEN_W){1'b0}}, row_length_reg} : '0;

    assign in_fire = in_valid && in_ready;

    clns_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    clns_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .char_code      (char_code),
        .row            (row),
        .col            (col),
        .row_length     (row_length_reg),
        .ctl            (ctl),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .nibble         (nibble),
        .wait_before_us (wait_before_us),
        .wait_after_us  (wait_after_us),
        .last           (last)
    );

endmodule

>>> dv/tb_char_lcd_nibble_sequencer.sv
// Self-checking testbench for the character-LCD nibble sequencer.
module tb_char_lcd_nibble_sequencer;

    typedef struct packed {
        logic [clns_pkg::OP_W-1:0]   op;
        logic [clns_pkg::CHAR_W-1:0] ch;
        logic [clns_pkg::ROW_W-1:0]  row;
        logic [clns_pkg::COL_W-1:0]  col;
    } lcd_cmd_t;

    typedef struct packed {
        logic                       rs;
        logic [clns_pkg::NIB_W-1:0] nib;
        logic [clns_pkg::WB_W-1:0]  wb;
        logic [clns_pkg::WA_W-1:0]  wa;
        logic                       lst;
    } transfer_t;

    // t_count: -1 checked by the predictor, 0 no transfers, 2 one typed byte
    typedef struct {
        lcd_cmd_t                    cmd;
        int                          t_count;
        logic                        t_rs;
        logic [clns_pkg::CHAR_W-1:0] t_byte;
        logic [clns_pkg::WA_W-1:0]   t_wa;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [clns_pkg::PADDR_W-1:0]   paddr;
    logic [clns_pkg::PDATA_W-1:0]   pwdata;
    logic [clns_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_ready;
    logic [clns_pkg::OP_W-1:0]      operation;
    logic [clns_pkg::CHAR_W-1:0]    char_code;
    logic [clns_pkg::ROW_W-1:0]     row;
    logic [clns_pkg::COL_W-1:0]     col;
    logic                           out_valid;
    logic                           out_ready;
    logic                           reg_select;
    logic [clns_pkg::NIB_W-1:0]     nibble;
    logic [clns_pkg::WB_W-1:0]      wait_before_us;
    logic [clns_pkg::WA_W-1:0]      wait_after_us;
    logic                           last;

    logic [clns_pkg::ROWLEN_W-1:0]  row_len_cfg;
    transfer_t                      next_xfers[$];
    transfer_t                      pending_xfers[$];
    stim_row_t                      directed_rows[$];
    int                             mismatch_count;
    bit                             idle_on;
    bit                             long_hold_req;

    char_lcd_nibble_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .char_code      (char_code),
        .row            (row),
        .col            (col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .nibble         (nibble),
        .wait_before_us (wait_before_us),
        .wait_after_us  (wait_after_us),
        .last           (last)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void add_transfer(logic rs, logic [clns_pkg::NIB_W-1:0] nib,
                                         logic [clns_pkg::WB_W-1:0] wb,
                                         logic [clns_pkg::WA_W-1:0] wa, logic lst);
        transfer_t t;
        t.rs  = rs;
        t.nib = nib;
        t.wb  = wb;
        t.wa  = wa;
        t.lst = lst;
        next_xfers.push_back(t);
    endfunction

    function automatic void add_byte(logic rs, logic [clns_pkg::CHAR_W-1:0] b,
                                     logic [clns_pkg::WA_W-1:0] wa_lo, logic lst);
        add_transfer(rs, b[7:4], '0, 13'd40, 1'b0);
        add_transfer(rs, b[3:0], '0, wa_lo, lst);
    endfunction

    function automatic void expand_command(lcd_cmd_t c);
        logic [clns_pkg::ROW_W-1:0]  r;
        logic [clns_pkg::COL_W-1:0]  cc;
        int                          base;
        logic [clns_pkg::CHAR_W-1:0] pos;
        r    = c.row - 3'd1;
        cc   = c.col - 6'd1;
        base = int'(r >> 1) * int'(row_len_cfg);
        if (r[0])
            base += 64;
        pos  = 8'h80 | 8'((base + int'(cc)) & 8'h7F);
        case (c.op)
            clns_pkg::OP_INIT:
            begin
                add_transfer(1'b0, 4'h3, 11'd1505, 13'd4145, 1'b0);
                add_transfer(1'b0, 4'h3, '0, 13'd145, 1'b0);
                add_transfer(1'b0, 4'h3, '0, 13'd40, 1'b0);
                add_transfer(1'b0, 4'h2, '0, 13'd40, 1'b0);
                add_byte(1'b0, 8'h28, 13'd40, 1'b0);
                add_byte(1'b0, 8'h0C, 13'd40, 1'b0);
                add_byte(1'b0, 8'h06, 13'd40, 1'b1);
            end
            clns_pkg::OP_PUTCH:     add_byte(1'b1, c.ch, 13'd40, 1'b1);
            clns_pkg::OP_GOTO:      add_byte(1'b0, pos, 13'd40, 1'b1);
            clns_pkg::OP_CLEAR:     add_byte(1'b0, 8'h01, 13'd1640, 1'b1);
            clns_pkg::OP_HOME:      add_byte(1'b0, 8'h02, 13'd1640, 1'b1);
            clns_pkg::OP_CUR_OFF:   add_byte(1'b0, 8'h0C, 13'd40, 1'b1);
            clns_pkg::OP_CUR_BLINK: add_byte(1'b0, 8'h0F, 13'd40, 1'b1);
            default:
            begin
            end
        endcase
    endfunction

    function automatic void table_row(logic [clns_pkg::OP_W-1:0] op,
                                      logic [clns_pkg::CHAR_W-1:0] ch,
                                      logic [clns_pkg::ROW_W-1:0] r,
                                      logic [clns_pkg::COL_W-1:0] c, int t_count,
                                      logic t_rs, logic [clns_pkg::CHAR_W-1:0] t_byte,
                                      logic [clns_pkg::WA_W-1:0] t_wa);
        stim_row_t s;
        s.cmd     = '{op: op, ch: ch, row: r, col: c};
        s.t_count = t_count;
        s.t_rs    = t_rs;
        s.t_byte  = t_byte;
        s.t_wa    = t_wa;
        directed_rows.push_back(s);
    endfunction

    function automatic lcd_cmd_t random_command();
        lcd_cmd_t c;
        c.op  = ($urandom_range(0, 19) == 0) ? clns_pkg::OP_NONE :
                clns_pkg::OP_W'($urandom_range(0, 6));
        c.ch  = clns_pkg::CHAR_W'($urandom());
        c.row = ($urandom_range(0, 7) == 0) ? clns_pkg::ROW_W'($urandom()) :
                clns_pkg::ROW_W'($urandom_range(1, 4));
        c.col = ($urandom_range(0, 7) == 0) ? clns_pkg::COL_W'($urandom()) :
                clns_pkg::COL_W'($urandom_range(1, 40));
        return c;
    endfunction

    task automatic send_cmd(input lcd_cmd_t c);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= c.op;
        char_code <= c.ch;
        row       <= c.row;
        col       <= c.col;
        do @(posedge clk); while (!in_ready);
        while (next_xfers.size() > 0)
            pending_xfers.push_back(next_xfers.pop_front());
    endtask

    // trailing pause covers a request with no transfers still in flight
    task automatic drain_transfers();
        in_valid <= 1'b0;
        while (pending_xfers.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_row_length(input logic [clns_pkg::ROWLEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= clns_pkg::ADDR_ROW_LENGTH;
        pwdata  <= {26'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        row_len_cfg  = value;
    endtask

    always @(posedge clk)
    begin : transfer_check
        transfer_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_xfers.size() == 0)
                report_mismatch($sformatf("unexpected transfer nibble=%h", nibble));
            else
            begin
                e = pending_xfers.pop_front();
                if (reg_select !== e.rs)
                    report_mismatch($sformatf("reg_select %b want %b", reg_select, e.rs));
                if (nibble !== e.nib)
                    report_mismatch($sformatf("nibble %h want %h", nibble, e.nib));
                if (wait_before_us !== e.wb)
                    report_mismatch($sformatf("wait_before_us %0d want %0d",
                                              wait_before_us, e.wb));
                if (wait_after_us !== e.wa)
                    report_mismatch($sformatf("wait_after_us %0d want %0d",
                                              wait_after_us, e.wa));
                if (last !== e.lst)
                    report_mismatch($sformatf("last %b want %b", last, e.lst));
            end
        end
    end

    initial
    begin : sink_pacing
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = 80;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int        plan [6];
        lcd_cmd_t  c;
        stim_row_t s;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        operation      = '0;
        char_code      = '0;
        row            = '0;
        col            = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        long_hold_req  = 1'b0;
        row_len_cfg    = clns_pkg::ROW_LENGTH_RESET;

        //        op                      ch     row   col    cnt rs    byte   wa_last
        table_row(clns_pkg::OP_INIT,      8'h00, 3'd0, 6'd0,  -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_PUTCH,     8'h00, 3'd1, 6'd1,   2, 1'b1, 8'h00, 13'd40);
        table_row(clns_pkg::OP_PUTCH,     8'hFF, 3'd7, 6'd63,  2, 1'b1, 8'hFF, 13'd40);
        table_row(clns_pkg::OP_PUTCH,     8'hA5, 3'd2, 6'd5,   2, 1'b1, 8'hA5, 13'd40);
        table_row(clns_pkg::OP_PUTCH,     8'h5A, 3'd5, 6'd42,  2, 1'b1, 8'h5A, 13'd40);
        table_row(clns_pkg::OP_PUTCH,     8'h80, 3'd0, 6'd0,   2, 1'b1, 8'h80, 13'd40);
        table_row(clns_pkg::OP_GOTO,      8'hFF, 3'd1, 6'd1,   2, 1'b0, 8'h80, 13'd40);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd2, 6'd1,   2, 1'b0, 8'hC0, 13'd40);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd3, 6'd1,  -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd4, 6'd40, -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd0, 6'd0,  -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd7, 6'd63, -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd5, 6'd17, -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd6, 6'd40, -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_GOTO,      8'h00, 3'd1, 6'd40, -1, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_CLEAR,     8'hFF, 3'd7, 6'd63,  2, 1'b0, 8'h01, 13'd1640);
        table_row(clns_pkg::OP_HOME,      8'h00, 3'd0, 6'd0,   2, 1'b0, 8'h02, 13'd1640);
        table_row(clns_pkg::OP_CUR_OFF,   8'h55, 3'd3, 6'd21,  2, 1'b0, 8'h0C, 13'd40);
        table_row(clns_pkg::OP_CUR_BLINK, 8'hAA, 3'd4, 6'd42,  2, 1'b0, 8'h0F, 13'd40);
        table_row(clns_pkg::OP_NONE,      8'hFF, 3'd7, 6'd63,  0, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_NONE,      8'h00, 3'd1, 6'd1,   0, 1'b0, 8'h00, 13'd0);
        table_row(clns_pkg::OP_INIT,      8'hFF, 3'd7, 6'd63, -1, 1'b0, 8'h00, 13'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
        begin
            s = directed_rows[i];
            if (s.t_count < 0)
                expand_command(s.cmd);
            else if (s.t_count == 2)
                add_byte(s.t_rs, s.t_byte, s.t_wa, 1'b1);
            send_cmd(s.cmd);
        end
        drain_transfers();

        plan = '{40, 8, 63, 0, 0, 20};
        plan[4] = $urandom_range(8, 40);
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_on = (ph != 5);
            write_row_length(clns_pkg::ROWLEN_W'(plan[ph]));
            for (int n = 0; n < 42; n++)
            begin
                if (ph == 1 && n == 4)
                    long_hold_req = 1'b1;
                c = random_command();
                expand_command(c);
                send_cmd(c);
            end
            drain_transfers();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/clns_pkg.sv
hw/rtl/clns_sequencer.sv
hw/rtl/clns_datapath.sv
hw/rtl/char_lcd_nibble_sequencer.sv
dv/tb_char_lcd_nibble_sequencer.sv
